// ===== sv/range_to_disparity_pixel_defines.svh =====
// Assertion macros for the range-to-disparity pixel block.
// Checks are clocked on clk and held off while arst_n is low.
`ifndef RANGE_TO_DISPARITY_PIXEL_DEFINES_SVH
`define RANGE_TO_DISPARITY_PIXEL_DEFINES_SVH

`ifndef SYNTHESIS
`define RTDP_ASSERT_IMP(lbl, cond, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (prop)) \
		else $error("rtdp check failed");
`define RTDP_ASSERT_NXT(lbl, cond, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (prop)) \
		else $error("rtdp check failed");
`else
`define RTDP_ASSERT_IMP(lbl, cond, prop)
`define RTDP_ASSERT_NXT(lbl, cond, prop)
`endif

`endif

// ===== sv/rtdp_pkg.sv =====
// Shared types and constants of the range-to-disparity pixel block.
// No dependencies; all other files but the defines header use it.
`timescale 1ns / 1ps

package rtdp_pkg;

	localparam int unsigned CFG_IDX_W = 8;

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_INV_FOCAL_X    = 8'd0,
		REG_INV_SKEW       = 8'd1,
		REG_INV_CENTER_X   = 8'd2,
		REG_INV_FOCAL_Y    = 8'd3,
		REG_INV_CENTER_Y   = 8'd4,
		REG_RIGHT_FOCAL_X  = 8'd5,
		REG_RIGHT_CENTER_X = 8'd6,
		REG_BASELINE_LEN   = 8'd7
	} cfg_reg_t;

	// 1000.0 in Q16.16
	localparam logic [31:0] RANGE_LIMIT = 32'd65536000;

	// square root unit
	localparam int unsigned SQ_IN_W   = 64;
	localparam int unsigned SQ_ROOT_W = 32;
	localparam int unsigned SQ_REM_W  = SQ_ROOT_W + 3;
	localparam logic [SQ_IN_W-1:0] N2_ONE = 64'h0001_0000_0000_0000;

	// divider unit
	localparam int unsigned DIV_N_W = 64;
	localparam int unsigned DIV_D_W = 32;
	localparam int unsigned DIV_Q_W = 41;
	localparam int unsigned DIV_STAGES = DIV_Q_W + 1;
	localparam logic [DIV_Q_W-1:0] DIV_T_SAT = 41'h100_0000_0000;

	// side data carried through the square root pipeline
	typedef struct packed {
		logic [11:0]        x;
		logic [11:0]        y;
		logic [31:0]        range_val;
		logic signed [31:0] xn;
		logic               keep;
	} sq_tag_t;

	// side data carried through the divider pipeline
	typedef struct packed {
		logic [11:0]        x;
		logic [11:0]        y;
		logic signed [31:0] xn;
		logic               keep;
	} div_tag_t;

endpackage

// ===== sv/rtdp_if.sv =====
// Channel interfaces of the range-to-disparity pixel block: pixel in,
// disparity out and configuration write. Depends on rtdp_pkg.
`timescale 1ns / 1ps

interface rtdp_pix_in_if;
	logic        valid;
	logic        ready;
	logic [11:0] pixel_x;
	logic [11:0] pixel_y;
	logic [31:0] range_val;

	modport source (output valid, output pixel_x, output pixel_y, output range_val,
		input ready);
	modport sink (input valid, input pixel_x, input pixel_y, input range_val,
		output ready);
endinterface

interface rtdp_pix_out_if;
	logic        valid;
	logic        ready;
	logic [11:0] out_x;
	logic [11:0] out_y;
	logic [15:0] disparity_scaled;

	modport source (output valid, output out_x, output out_y, output disparity_scaled,
		input ready);
	modport sink (input valid, input out_x, input out_y, input disparity_scaled,
		output ready);
endinterface

interface rtdp_cfg_if;
	import rtdp_pkg::*;
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [31:0]          data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// ===== sv/range_to_disparity_pixel.sv =====
// Range-to-disparity pixel converter, top level. Uses rtdp_pkg, rtdp_if,
// rtdp_sqrt, rtdp_div and range_to_disparity_pixel_defines.svh.
// The 32-stage square root and 42-stage divider pipelines take one pixel per
// cycle while the output is not stalled. A full output register that is not
// taken stalls the whole pipeline; dropped pixels leave a bubble at the output.
// Reset: arst_n clears all valid bits and the configuration registers to 0.
`timescale 1ns / 1ps
`include "range_to_disparity_pixel_defines.svh"

module range_to_disparity_pixel #(
	parameter int unsigned COORD_RANGE     = 4096,
	parameter int unsigned DISPARITY_SCALE = 256
) (
	input  logic                  clk,
	input  logic                  arst_n,
	rtdp_pix_in_if.sink           pix_in,
	rtdp_pix_out_if.source        pix_out,
	rtdp_cfg_if.sink              cfg
);
	import rtdp_pkg::*;

	localparam logic [16:0] COORD_LIM = 17'(COORD_RANGE);

	// clamp a 47-bit signed sum to 32-bit signed
	function automatic logic signed [31:0] sat32(input logic signed [46:0] v);
		logic signed [31:0] r;
		if (v[46]) begin
			r = (&v[46:31]) ? v[31:0] : 32'sh8000_0000;
		end else begin
			r = (|v[46:31]) ? 32'sh7FFF_FFFF : v[31:0];
		end
		return r;
	endfunction

	// configuration registers
	logic signed [31:0] inv_focal_x_q, inv_skew_q, inv_center_x_q;
	logic signed [31:0] inv_focal_y_q, inv_center_y_q;
	logic signed [31:0] right_focal_x_q, right_center_x_q;
	logic [31:0]        baseline_len_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inv_focal_x_q    <= '0;
			inv_skew_q       <= '0;
			inv_center_x_q   <= '0;
			inv_focal_y_q    <= '0;
			inv_center_y_q   <= '0;
			right_focal_x_q  <= '0;
			right_center_x_q <= '0;
			baseline_len_q   <= '0;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_INV_FOCAL_X:    inv_focal_x_q    <= cfg.data;
				REG_INV_SKEW:       inv_skew_q       <= cfg.data;
				REG_INV_CENTER_X:   inv_center_x_q   <= cfg.data;
				REG_INV_FOCAL_Y:    inv_focal_y_q    <= cfg.data;
				REG_INV_CENTER_Y:   inv_center_y_q   <= cfg.data;
				REG_RIGHT_FOCAL_X:  right_focal_x_q  <= cfg.data;
				REG_RIGHT_CENTER_X: right_center_x_q <= cfg.data;
				REG_BASELINE_LEN:   baseline_len_q   <= cfg.data;
				default: ;
			endcase
		end
	end

	// pipeline control: advance unless a finished result waits
	logic adv;
	logic out_vld_s11;
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6;
	logic vld_s7, vld_s8, vld_s9, vld_s10;
	logic keep_s10;
	logic sq_vld, dv_vld;

	assign adv          = !out_vld_s11 || pix_out.ready;
	assign pix_in.ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1      <= 1'b0;
			vld_s2      <= 1'b0;
			vld_s3      <= 1'b0;
			vld_s4      <= 1'b0;
			vld_s5      <= 1'b0;
			vld_s6      <= 1'b0;
			vld_s7      <= 1'b0;
			vld_s8      <= 1'b0;
			vld_s9      <= 1'b0;
			vld_s10     <= 1'b0;
			out_vld_s11 <= 1'b0;
		end else if (adv) begin
			vld_s1      <= pix_in.valid;
			vld_s2      <= vld_s1;
			vld_s3      <= vld_s2;
			vld_s4      <= vld_s3;
			vld_s5      <= vld_s4;
			vld_s6      <= sq_vld;
			vld_s7      <= dv_vld;
			vld_s8      <= vld_s7;
			vld_s9      <= vld_s8;
			vld_s10     <= vld_s9;
			out_vld_s11 <= vld_s10 && keep_s10;
		end
	end

	// stage 1: capture the pixel, flag the ones that give no result
	logic [11:0] x_s1, y_s1;
	logic [31:0] rng_s1;
	logic        keep_s1;

	always_ff @(posedge clk) begin
		if (adv) begin
			x_s1    <= pix_in.pixel_x;
			y_s1    <= pix_in.pixel_y;
			rng_s1  <= pix_in.range_val;
			keep_s1 <= ({5'b0, pix_in.pixel_x} < COORD_LIM) &&
				({5'b0, pix_in.pixel_y} < COORD_LIM) &&
				(pix_in.range_val != '0) && (pix_in.range_val < RANGE_LIMIT);
		end
	end

	// stage 2: back-projection products
	logic [11:0]        x_s2, y_s2;
	logic [31:0]        rng_s2;
	logic               keep_s2;
	logic signed [44:0] pxa_s2, pyb_s2, pyd_s2;

	always_ff @(posedge clk) begin
		if (adv) begin
			x_s2    <= x_s1;
			y_s2    <= y_s1;
			rng_s2  <= rng_s1;
			keep_s2 <= keep_s1;
			pxa_s2  <= 45'(inv_focal_x_q) * 45'($signed({1'b0, x_s1}));
			pyb_s2  <= 45'(inv_skew_q) * 45'($signed({1'b0, y_s1}));
			pyd_s2  <= 45'(inv_focal_y_q) * 45'($signed({1'b0, y_s1}));
		end
	end

	// stage 3: sum and clamp the normalized ray
	logic [11:0]        x_s3, y_s3;
	logic [31:0]        rng_s3;
	logic               keep_s3;
	logic signed [31:0] xn_s3, yn_s3;

	always_ff @(posedge clk) begin
		if (adv) begin
			x_s3    <= x_s2;
			y_s3    <= y_s2;
			rng_s3  <= rng_s2;
			keep_s3 <= keep_s2;
			xn_s3   <= sat32(47'(pxa_s2) + 47'(pyb_s2) + 47'(inv_center_x_q));
			yn_s3   <= sat32(47'(pyd_s2) + 47'(inv_center_y_q));
		end
	end

	// stage 4: squares
	logic [11:0]        x_s4, y_s4;
	logic [31:0]        rng_s4;
	logic               keep_s4;
	logic signed [31:0] xn_s4;
	logic [63:0]        xsq_s4, ysq_s4;

	always_ff @(posedge clk) begin
		if (adv) begin
			x_s4    <= x_s3;
			y_s4    <= y_s3;
			rng_s4  <= rng_s3;
			keep_s4 <= keep_s3;
			xn_s4   <= xn_s3;
			xsq_s4  <= 64'(xn_s3) * 64'(xn_s3);
			ysq_s4  <= 64'(yn_s3) * 64'(yn_s3);
		end
	end

	// stage 5: squared ray length
	sq_tag_t     tag_s5;
	logic [63:0] n2_s5;

	always_ff @(posedge clk) begin
		if (adv) begin
			tag_s5 <= '{x: x_s4, y: y_s4, range_val: rng_s4, xn: xn_s4, keep: keep_s4};
			n2_s5  <= xsq_s4 + ysq_s4 + N2_ONE;
		end
	end

	// ray length
	logic [SQ_ROOT_W-1:0] sq_root;
	sq_tag_t              sq_tag;

	rtdp_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.in_vld   (vld_s5),
		.in_rad   (n2_s5),
		.in_tag   (tag_s5),
		.out_vld  (sq_vld),
		.out_root (sq_root),
		.out_tag  (sq_tag)
	);

	// stage 6: baseline times ray length
	div_tag_t    tag_s6;
	logic [31:0] den_s6;
	logic [63:0] bl_s6;

	always_ff @(posedge clk) begin
		if (adv) begin
			tag_s6 <= '{x: sq_tag.x, y: sq_tag.y, xn: sq_tag.xn, keep: sq_tag.keep};
			den_s6 <= sq_tag.range_val;
			bl_s6  <= 64'(baseline_len_q) * 64'(sq_root);
		end
	end

	// baseline shift along the ray, divided by range
	logic [DIV_Q_W-1:0] dv_t;
	div_tag_t           dv_tag;

	rtdp_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (adv),
		.in_vld  (vld_s6),
		.in_num  (bl_s6),
		.in_den  (den_s6),
		.in_tag  (tag_s6),
		.out_vld (dv_vld),
		.out_t   (dv_t),
		.out_tag (dv_tag)
	);

	// stage 7: shifted x, clamped and floored to Q.16
	logic signed [42:0] udiff;
	logic signed [39:0] uclamp;
	logic [11:0]        x_s7, y_s7;
	logic               keep_s7;
	logic signed [31:0] u_s7;

	always_comb begin
		udiff = 43'(dv_tag.xn) - $signed({2'b00, dv_t});
		if (udiff[42]) begin
			uclamp = (&udiff[42:39]) ? udiff[39:0] : 40'sh80_0000_0000;
		end else begin
			uclamp = (|udiff[42:39]) ? 40'sh7F_FFFF_FFFF : udiff[39:0];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			x_s7    <= dv_tag.x;
			y_s7    <= dv_tag.y;
			keep_s7 <= dv_tag.keep;
			u_s7    <= uclamp[39:8];
		end
	end

	// stage 8: right focal product
	logic [11:0]        x_s8, y_s8;
	logic               keep_s8;
	logic signed [63:0] fu_s8;

	always_ff @(posedge clk) begin
		if (adv) begin
			x_s8    <= x_s7;
			y_s8    <= y_s7;
			keep_s8 <= keep_s7;
			fu_s8   <= 64'(right_focal_x_q) * 64'(u_s7);
		end
	end

	// stage 9: right column, drop points left of the right image
	logic signed [65:0] rx_sum;
	logic [11:0]        x_s9, y_s9;
	logic               keep_s9;
	logic signed [65:0] rx_s9;

	assign rx_sum = 66'(fu_s8) +
		$signed({{18{right_center_x_q[31]}}, right_center_x_q, 16'h0000});

	always_ff @(posedge clk) begin
		if (adv) begin
			x_s9    <= x_s8;
			y_s9    <= y_s8;
			keep_s9 <= keep_s8 && !rx_sum[65];
			rx_s9   <= rx_sum;
		end
	end

	// stage 10: disparity in Q.32
	logic signed [65:0] dsum;
	logic [11:0]        x_s10, y_s10;
	logic               dpos_s10;
	logic [43:0]        d_s10;

	assign dsum = $signed({22'b0, x_s9, 32'h0000_0000}) - rx_s9;

	always_ff @(posedge clk) begin
		if (adv) begin
			x_s10    <= x_s9;
			y_s10    <= y_s9;
			keep_s10 <= keep_s9;
			dpos_s10 <= !dsum[65] && (dsum != '0);
			d_s10    <= dsum[43:0];
		end
	end

	// stage 11: scale, truncate, saturate or zero into the output register
	logic [63:0] dprod;
	logic [15:0] disp_s11;
	logic [11:0] x_s11, y_s11;

	assign dprod = 64'(d_s10) * 64'(DISPARITY_SCALE);

	always_ff @(posedge clk) begin
		if (adv) begin
			x_s11 <= x_s10;
			y_s11 <= y_s10;
			if (!dpos_s10) begin
				disp_s11 <= '0;
			end else if (dprod[63:48] != '0) begin
				disp_s11 <= 16'hFFFF;
			end else begin
				disp_s11 <= dprod[47:32];
			end
		end
	end

	assign pix_out.valid            = out_vld_s11;
	assign pix_out.out_x            = x_s11;
	assign pix_out.out_y            = y_s11;
	assign pix_out.disparity_scaled = disp_s11;

	// checks
	`RTDP_ASSERT_IMP(a_stall_blocks_input, pix_out.valid && !pix_out.ready, !pix_in.ready)
	`RTDP_ASSERT_IMP(a_root_at_least_one, sq_vld, sq_root[31:24] != 8'h00)
	`RTDP_ASSERT_IMP(a_div_saturated, dv_vld, dv_t <= DIV_T_SAT)
	`RTDP_ASSERT_NXT(a_baseline_write, cfg.valid && (cfg.index == REG_BASELINE_LEN), baseline_len_q == $past(cfg.data))

endmodule

// ===== sv/rtdp_sqrt.sv =====
// Pipelined integer square root, one root bit per stage, with side data.
// Depends on rtdp_pkg.
`timescale 1ns / 1ps

module rtdp_sqrt (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              adv,
	input  logic                              in_vld,
	input  logic [rtdp_pkg::SQ_IN_W-1:0]      in_rad,
	input  rtdp_pkg::sq_tag_t                 in_tag,
	output logic                              out_vld,
	output logic [rtdp_pkg::SQ_ROOT_W-1:0]    out_root,
	output rtdp_pkg::sq_tag_t                 out_tag
);
	import rtdp_pkg::*;

	logic [SQ_REM_W-1:0]  rem_s  [SQ_ROOT_W];
	logic [SQ_ROOT_W-1:0] root_s [SQ_ROOT_W];
	logic [SQ_IN_W-1:0]   rad_s  [SQ_ROOT_W];
	sq_tag_t              tag_s  [SQ_ROOT_W];
	logic                 vld_s  [SQ_ROOT_W];

	genvar i;
	for (i = 0; i < SQ_ROOT_W; i++) begin : g_stage
		logic [SQ_REM_W-1:0]  rem_in;
		logic [SQ_ROOT_W-1:0] root_in;
		logic [SQ_IN_W-1:0]   rad_in;
		sq_tag_t              tag_in;
		logic                 vld_in;
		logic [SQ_REM_W-1:0]  trial;
		logic [SQ_REM_W-1:0]  cand;

		if (i == 0) begin : g_head
			assign rem_in  = '0;
			assign root_in = '0;
			assign rad_in  = in_rad;
			assign tag_in  = in_tag;
			assign vld_in  = in_vld;
		end else begin : g_body
			assign rem_in  = rem_s[i-1];
			assign root_in = root_s[i-1];
			assign rad_in  = rad_s[i-1];
			assign tag_in  = tag_s[i-1];
			assign vld_in  = vld_s[i-1];
		end

		// bring down the next two radicand bits, try the next root bit
		assign trial = {rem_in[SQ_REM_W-3:0], rad_in[SQ_IN_W-1 -: 2]};
		assign cand  = {1'b0, root_in, 2'b01};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i] <= 1'b0;
			end else if (adv) begin
				vld_s[i] <= vld_in;
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				rad_s[i] <= rad_in << 2;
				tag_s[i] <= tag_in;
				if (trial >= cand) begin
					rem_s[i]  <= trial - cand;
					root_s[i] <= {root_in[SQ_ROOT_W-2:0], 1'b1};
				end else begin
					rem_s[i]  <= trial;
					root_s[i] <= {root_in[SQ_ROOT_W-2:0], 1'b0};
				end
			end
		end
	end

	assign out_vld  = vld_s[SQ_ROOT_W-1];
	assign out_root = root_s[SQ_ROOT_W-1];
	assign out_tag  = tag_s[SQ_ROOT_W-1];

endmodule

// ===== sv/rtdp_div.sv =====
// Pipelined restoring divider, one quotient bit per stage after the first,
// quotient saturated to 2^40, with side data. Depends on rtdp_pkg.
`timescale 1ns / 1ps

module rtdp_div (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            adv,
	input  logic                            in_vld,
	input  logic [rtdp_pkg::DIV_N_W-1:0]    in_num,
	input  logic [rtdp_pkg::DIV_D_W-1:0]    in_den,
	input  rtdp_pkg::div_tag_t              in_tag,
	output logic                            out_vld,
	output logic [rtdp_pkg::DIV_Q_W-1:0]    out_t,
	output rtdp_pkg::div_tag_t              out_tag
);
	import rtdp_pkg::*;

	logic [DIV_D_W-1:0] rem_s [DIV_STAGES];
	logic [DIV_Q_W-1:0] low_s [DIV_STAGES];
	logic [DIV_Q_W-1:0] q_s   [DIV_STAGES];
	logic [DIV_D_W-1:0] den_s [DIV_STAGES];
	logic               ovf_s [DIV_STAGES];
	div_tag_t           tag_s [DIV_STAGES];
	logic               vld_s [DIV_STAGES];

	// first stage: flag quotients past 41 bits, load the partial remainder
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else if (adv) begin
			vld_s[0] <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rem_s[0] <= DIV_D_W'(in_num[DIV_N_W-1:DIV_Q_W]);
			ovf_s[0] <= DIV_D_W'(in_num[DIV_N_W-1:DIV_Q_W]) >= in_den;
			low_s[0] <= in_num[DIV_Q_W-1:0];
			q_s[0]   <= '0;
			den_s[0] <= in_den;
			tag_s[0] <= in_tag;
		end
	end

	genvar k;
	for (k = 1; k < DIV_STAGES; k++) begin : g_stage
		logic [DIV_D_W:0] trial;
		logic [DIV_D_W:0] diff;
		logic             ge;

		assign trial = {rem_s[k-1], low_s[k-1][DIV_Q_W-1]};
		assign diff  = trial - {1'b0, den_s[k-1]};
		assign ge    = trial >= {1'b0, den_s[k-1]};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (adv) begin
				vld_s[k] <= vld_s[k-1];
			end
		end

		// shift in one dividend bit, subtract when it fits
		always_ff @(posedge clk) begin
			if (adv) begin
				rem_s[k] <= ge ? diff[DIV_D_W-1:0] : trial[DIV_D_W-1:0];
				q_s[k]   <= {q_s[k-1][DIV_Q_W-2:0], ge};
				low_s[k] <= low_s[k-1] << 1;
				den_s[k] <= den_s[k-1];
				ovf_s[k] <= ovf_s[k-1];
				tag_s[k] <= tag_s[k-1];
			end
		end
	end

	// saturate the quotient at 2^40
	assign out_vld = vld_s[DIV_STAGES-1];
	assign out_tag = tag_s[DIV_STAGES-1];
	assign out_t   = (ovf_s[DIV_STAGES-1] || (q_s[DIV_STAGES-1] > DIV_T_SAT)) ?
		DIV_T_SAT : q_s[DIV_STAGES-1];

endmodule
